// ===== rtl/core/id_allocator_with_tag_table_unit_assert.svh =====
// Assertion macros used by the checker file of the id allocator.
// Depends on signals named clk_i and rst_ni in the module that uses them.
`ifndef ID_ALLOCATOR_WITH_TAG_TABLE_UNIT_ASSERT_SVH
`define ID_ALLOCATOR_WITH_TAG_TABLE_UNIT_ASSERT_SVH

// Clocked assertion that is switched off while reset is active.
`define IDA_ASSERT(lbl, prp) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prp)) \
    else $error("id allocator check failed");

// Clocked assertion that also holds while reset is active.
`define IDA_ASSERT_ALWAYS(lbl, prp) \
  lbl: assert property (@(posedge clk_i) (prp)) \
    else $error("id allocator reset check failed");

`endif

// ===== rtl/core/ida_pkg.sv =====
// Package of the id allocator: field widths, opcodes, status codes and item types.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ida_pkg;

  // Default sizes of the id space and of a stored tag.
  localparam int unsigned MAX_IDS_DEF  = 1024;
  localparam int unsigned TAG_BITS_DEF = 32;

  // Fixed widths of the item fields.
  localparam int unsigned IdentW    = 16;
  localparam int unsigned TagW      = 32;
  localparam int unsigned GrantW    = 10;
  localparam int unsigned LiveCntW  = 11;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_SET     = 2'd2,
    OP_GET     = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_OVERFLOW  = 2'd3
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [IdentW-1:0]  ident;
    logic [TagW-1:0]    tag_in;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [GrantW-1:0]    granted_id;
    logic [TagW-1:0]      tag_out;
    logic [LiveCntW-1:0]  live_count;
  } rsp_t;

  // Controls of the free queue.
  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } fq_ctrl_t;

  // Controls of the tag store.
  typedef struct packed {
    logic rd;
    logic wr;
  } ts_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ida_free_queue.sv =====
// FIFO of released ids kept in a synchronous memory with head, tail and fill count.
// Depends on ida_pkg for the control struct.
`default_nettype none

module ida_free_queue #(
  parameter int unsigned MAX_IDS = ida_pkg::MAX_IDS_DEF
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  ida_pkg::fq_ctrl_t                  ctrl_i,
  input  wire  [$clog2(MAX_IDS)-1:0]         push_id_i,
  output logic [$clog2(MAX_IDS)-1:0]         head_id_o,
  output logic                               empty_o,
  output logic                               full_o
);

  localparam int unsigned IdW  = $clog2(MAX_IDS);
  localparam int unsigned CntW = $clog2(MAX_IDS + 1);
  localparam logic [IdW-1:0]  LastIdx = IdW'(MAX_IDS - 1);
  localparam logic [CntW-1:0] Depth   = CntW'(MAX_IDS);

  logic [IdW-1:0]  mem [MAX_IDS];
  logic [IdW-1:0]  head_q, head_d;
  logic [IdW-1:0]  tail_q, tail_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [IdW-1:0]  rdata_q;

  // Storage: one write at the tail, one registered read at the head.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[tail_q] <= push_id_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem[head_q];
    end
  end

  // Pointer and fill updates; the caller never pushes when full or pops when empty.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (ctrl_i.pop) begin
      head_d = (head_q == LastIdx) ? '0 : head_q + IdW'(1);
      fill_d = fill_q - CntW'(1);
    end
    if (ctrl_i.push) begin
      tail_d = (tail_q == LastIdx) ? '0 : tail_q + IdW'(1);
      fill_d = fill_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  assign head_id_o = rdata_q;
  assign empty_o   = (fill_q == '0);
  assign full_o    = (fill_q == Depth);

endmodule

`default_nettype wire

// ===== rtl/core/ida_tag_store.sv =====
// Tag word per id in a synchronous memory, with a clearing pass after reset.
// Depends on ida_pkg for the control struct.
`default_nettype none

module ida_tag_store #(
  parameter int unsigned MAX_IDS = ida_pkg::MAX_IDS_DEF,
  parameter int unsigned TAG_W   = ida_pkg::TAG_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  ida_pkg::ts_ctrl_t                 ctrl_i,
  input  wire  [$clog2(MAX_IDS)-1:0]        rd_addr_i,
  input  wire  [$clog2(MAX_IDS)-1:0]        wr_addr_i,
  input  wire  [TAG_W-1:0]                  wdata_i,
  output logic [TAG_W-1:0]                  rdata_o,
  output logic                              clearing_o
);

  localparam int unsigned IdW = $clog2(MAX_IDS);
  localparam logic [IdW-1:0] LastIdx = IdW'(MAX_IDS - 1);

  logic [TAG_W-1:0] mem [MAX_IDS];
  logic [TAG_W-1:0] rdata_q;
  logic             clr_q;
  logic [IdW-1:0]   clr_idx_q;

  // Clearing pass: one entry per cycle from the first to the last.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_idx_q <= '0;
    end else if (clr_q) begin
      clr_idx_q <= clr_idx_q + IdW'(1);
      if (clr_idx_q == LastIdx) begin
        clr_q <= 1'b0;
      end
    end
  end

  // Storage: the clearing pass owns the write port until it is done.
  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem[clr_idx_q] <= '0;
    end else if (ctrl_i.wr) begin
      mem[wr_addr_i] <= wdata_i;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem[rd_addr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_q;

endmodule

`default_nettype wire

// ===== rtl/core/id_allocator_with_tag_table_unit.sv =====
// The result is worked out in the execute state after an accept, and the result strobe
// and word are registered as that state ends. A new item is taken only in idle; busy
// is high in the execute state that follows an accept, in which the free queue and tag
// memories, read at the accept edge, are modified.
// The receiver cannot stall; each result is shown for exactly one cycle.
// Reset: the tag memory is cleared one entry per cycle; busy stays high through the
// clearing pass after reset is released.
`default_nettype none

module id_allocator_with_tag_table_unit #(
  parameter int unsigned MAX_IDS  = ida_pkg::MAX_IDS_DEF,
  parameter int unsigned TAG_BITS = ida_pkg::TAG_BITS_DEF
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            start,
  input  ida_pkg::req_t  req_i,
  output logic           busy,
  output logic           valid_o,
  output ida_pkg::rsp_t  rsp_o
);

  localparam int unsigned IdW  = $clog2(MAX_IDS);
  localparam int unsigned CntW = $clog2(MAX_IDS + 1);
  localparam int unsigned TW   = (TAG_BITS < ida_pkg::TagW) ? TAG_BITS : ida_pkg::TagW;
  localparam logic [CntW-1:0] IdCount = CntW'(MAX_IDS);
  localparam logic [ida_pkg::IdentW:0] IdentLimit = (ida_pkg::IdentW + 1)'(MAX_IDS);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_e;

  state_e              state_q, state_d;
  ida_pkg::req_t       req_q;
  ida_pkg::rsp_t       rsp_q, rsp_d;
  logic                valid_q;
  logic [CntW-1:0]     fresh_q, fresh_d;
  logic [CntW-1:0]     live_q, live_d;

  logic                accept;
  logic                in_range;
  ida_pkg::fq_ctrl_t   fq_ctrl;
  logic [IdW-1:0]      fq_head_id;
  logic                fq_empty;
  logic                fq_full;
  ida_pkg::ts_ctrl_t   ts_ctrl;
  logic [TW-1:0]       ts_wdata;
  logic [TW-1:0]       ts_rdata;
  logic                ts_clearing;
  ida_pkg::status_e    status;
  logic [IdW-1:0]      grant;
  logic [TW-1:0]       tag_rd;

  assign busy     = (state_q != S_IDLE);
  assign accept   = start && !busy;
  assign in_range = ({1'b0, req_q.ident} < IdentLimit);

  ida_free_queue #(
    .MAX_IDS (MAX_IDS)
  ) u_free_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (fq_ctrl),
    .push_id_i (req_q.ident[IdW-1:0]),
    .head_id_o (fq_head_id),
    .empty_o   (fq_empty),
    .full_o    (fq_full)
  );

  ida_tag_store #(
    .MAX_IDS (MAX_IDS),
    .TAG_W   (TW)
  ) u_tag_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ts_ctrl),
    .rd_addr_i  (req_i.ident[IdW-1:0]),
    .wr_addr_i  (req_q.ident[IdW-1:0]),
    .wdata_i    (ts_wdata),
    .rdata_o    (ts_rdata),
    .clearing_o (ts_clearing)
  );

  // Sequencing: wait out the clearing pass, then accept, then modify and respond.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (!ts_clearing) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_EXEC;
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  // Operation: memories were read at the accept edge, updates are written back here.
  always_comb begin
    fq_ctrl      = '0;
    ts_ctrl      = '0;
    fq_ctrl.rd   = accept;
    ts_ctrl.rd   = accept;
    ts_wdata     = '0;
    fresh_d      = fresh_q;
    live_d       = live_q;
    status       = ida_pkg::ST_OK;
    grant        = '0;
    tag_rd       = '0;
    if (state_q == S_EXEC) begin
      if (req_q.op == ida_pkg::OP_ALLOC) begin
        if (!fq_empty) begin
          grant       = fq_head_id;
          fq_ctrl.pop = 1'b1;
        end else if (fresh_q < IdCount) begin
          grant   = fresh_q[IdW-1:0];
          fresh_d = fresh_q + CntW'(1);
        end else begin
          status = ida_pkg::ST_EXHAUSTED;
        end
        if (status == ida_pkg::ST_OK && live_q < IdCount) begin
          live_d = live_q + CntW'(1);
        end
      end else if (!in_range) begin
        status = ida_pkg::ST_RANGE;
      end else begin
        case (req_q.op)
          ida_pkg::OP_RELEASE: begin
            if (fq_full) begin
              status = ida_pkg::ST_OVERFLOW;
            end else begin
              ts_ctrl.wr   = 1'b1;
              fq_ctrl.push = 1'b1;
              if (live_q != '0) begin
                live_d = live_q - CntW'(1);
              end
            end
          end
          ida_pkg::OP_SET: begin
            ts_ctrl.wr = 1'b1;
            ts_wdata   = req_q.tag_in[TW-1:0];
          end
          ida_pkg::OP_GET: begin
            tag_rd = ts_rdata;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Result word as seen by the receiver.
  always_comb begin
    rsp_d.status     = status;
    rsp_d.granted_id = ida_pkg::GrantW'(grant);
    rsp_d.tag_out    = ida_pkg::TagW'(tag_rd);
    rsp_d.live_count = ida_pkg::LiveCntW'(live_d);
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      valid_q <= 1'b0;
      fresh_q <= '0;
      live_q  <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == S_EXEC);
      fresh_q <= fresh_d;
      live_q  <= live_d;
    end
  end

  // Payload registers for the held item and the result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (state_q == S_EXEC) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = valid_q;
  assign rsp_o   = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/core/ida_checker.sv =====
// Port-level checks of the id allocator, bound to the top level.
// Depends on ida_pkg and the assertion macros header.
`default_nettype none

`include "id_allocator_with_tag_table_unit_assert.svh"

module ida_checker (
  input wire           clk_i,
  input wire           rst_ni,
  input wire           start,
  input wire           busy,
  input wire           valid_o,
  input ida_pkg::rsp_t rsp_o
);

  logic accept;
  logic fail_rsp;
  assign accept   = start && !busy;
  assign fail_rsp = valid_o && (rsp_o.status != ida_pkg::ST_OK);

  // An accepted item holds the block busy for the next cycle.
  `IDA_ASSERT(a_busy_after_accept, accept |=> busy)

  // Every accepted item gets its result strobe.
  `IDA_ASSERT(a_result_follows, accept |-> ##2 valid_o)

  // A result strobe lasts one cycle.
  `IDA_ASSERT(a_strobe_single, valid_o |=> !valid_o)

  // A failed operation grants no id and returns no tag.
  `IDA_ASSERT(a_fail_zero, fail_rsp |-> (rsp_o.granted_id == '0 && rsp_o.tag_out == '0))

  // No result is strobed while reset is held.
  `IDA_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !valid_o)

endmodule

bind id_allocator_with_tag_table_unit ida_checker u_ida_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start   (start),
  .busy    (busy),
  .valid_o (valid_o),
  .rsp_o   (rsp_o)
);

`default_nettype wire
